### src/cfbb_pkg.sv
// shared types and constants for the cone frustum bounding box unit
// no dependencies
package cfbb_pkg;

  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int DIFF_W   = 33;
  localparam int MAG_W    = 30;
  localparam int SQ_W     = 60;
  localparam int SUM_W    = 62;
  localparam int QUO_W    = 33;
  localparam int FAC_W    = 17;
  localparam int EXT_W    = 32;
  localparam int EDGE_W   = 35;
  localparam int SHIFT_W  = 2;

  localparam int IN_DATA_W  = 6 * COORD_W + 2 * RADIUS_W;
  localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 6 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]       radius_t;

endpackage

### src/cone_frustum_bounding_box_unit.sv
// top level of the cone frustum axis-aligned bounding box pipeline
// depends on cfbb_pkg
//
//  channel | direction | tdata fields (lowest bit first)
//  in_     | slave     | begin_x begin_y begin_z end_x end_y end_z radius_first radius_second
//  out_    | master    | low_x low_y low_z high_x high_y high_z
//
// one transaction per cycle sustained while out_tready does not stall; the depth of
// the pipeline comes mostly from the restoring divider (one quotient bit per stage)
// and the square root (one result bit per stage).
// reset clears the stage valid bits only; payload registers are not reset.
// a stall on out_tready freezes every stage at once, so nothing is lost.
module cone_frustum_bounding_box_unit #(
  parameter int AXES = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // begin_x, begin_y, begin_z, end_x, end_y, end_z, radius_first, radius_second, zero pad
  input  logic [cfbb_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // low_x, low_y, low_z, high_x, high_y, high_z
  output logic [cfbb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cfbb_pkg::*;

  // stage plan:
  // 0 diff/mag, 1 normalize, 2 squares, 3 sums, 4..36 divide (33 bits),
  // 37..53 sqrt (17 bits), then products, edges, min/max+sat
  localparam int DIV_BITS  = QUO_W;
  localparam int SQ_BITS   = FAC_W;
  localparam int S_DIV0    = 4;
  localparam int S_SQ0     = S_DIV0 + DIV_BITS;
  localparam int S_MUL     = S_SQ0 + SQ_BITS;
  localparam int NSTAGE    = S_MUL + 3;
  localparam int PROD_W    = RADIUS_W + FAC_W;

  logic adv;
  logic [NSTAGE-1:0] vld_r;
  assign adv        = out_tready || !out_tvalid;
  assign in_tready  = adv && rst_n;
  assign out_tvalid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_tvalid};
    end
  end

  // carried payload: end points and radii
  coord_t  bp_r [NSTAGE][3];
  coord_t  ep_r [NSTAGE][3];
  radius_t r0_r [NSTAGE];
  radius_t r1_r [NSTAGE];

  // stage 0: magnitudes of axis differences
  logic [DIFF_W-1:0] mag0_r [3];
  // stage 1: normalized magnitudes
  logic [MAG_W-1:0] mag1_r [3];
  // stage 2: squares
  logic [SQ_W-1:0] sq_r [3];
  // divider state per axis
  logic [SUM_W:0]   rem_r [NSTAGE][3];
  logic [QUO_W-1:0] quo_r [NSTAGE][3];
  logic [SUM_W-1:0] den_r [NSTAGE];
  // sqrt state per axis
  logic [QUO_W:0]   srem_r [NSTAGE][3];
  logic [FAC_W-1:0] root_r [NSTAGE][3];
  // products and edges
  logic [EXT_W-1:0]  x0_r [3];
  logic [EXT_W-1:0]  x1_r [3];
  logic signed [EDGE_W-1:0] a_r [3], b_r [3], c_r [3], e_r [3];
  coord_t lo_r [3], hi_r [3];

  // stage 0
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [DIFF_W-1:0] d;
        bp_r[0][i] <= in_tdata[i*COORD_W +: COORD_W];
        ep_r[0][i] <= in_tdata[(3+i)*COORD_W +: COORD_W];
        d = DIFF_W'(signed'(in_tdata[(3+i)*COORD_W +: COORD_W]))
          - DIFF_W'(signed'(in_tdata[i*COORD_W +: COORD_W]));
        mag0_r[i] <= (i < AXES) ? (d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d)) : '0;
      end
      r0_r[0] <= in_tdata[6*COORD_W +: RADIUS_W];
      r1_r[0] <= in_tdata[6*COORD_W+RADIUS_W +: RADIUS_W];
    end
  end

  // stage 1: shift so the largest magnitude is below 2^30
  logic [DIFF_W-1:0] mmax;
  logic [SHIFT_W-1:0] kshift;
  always_comb begin
    mmax = mag0_r[0];
    for (int i = 1; i < 3; i++) if (mag0_r[i] > mmax) mmax = mag0_r[i];
    if (mmax[32])      kshift = 2'd3;
    else if (mmax[31]) kshift = 2'd2;
    else if (mmax[30]) kshift = 2'd1;
    else               kshift = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) mag1_r[i] <= MAG_W'(mag0_r[i] >> kshift);
    end
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= SQ_W'(mag1_r[i] * mag1_r[i]);
    end
  end

  // stage 3: total and partial sums; divider initial step
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [SUM_W-1:0] tot;
      tot = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      den_r[3] <= tot;
      for (int i = 0; i < 3; i++) begin
        rem_r[3][i] <= {1'b0, tot - SUM_W'(sq_r[i])};
        quo_r[3][i] <= '0;
      end
    end
  end

  // divider stages: first compares without shift, then 32 shifted steps
  for (genvar s = S_DIV0; s < S_SQ0; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[s] <= den_r[s-1];
        for (int i = 0; i < 3; i++) begin
          logic [SUM_W:0] rm;
          rm = (s == S_DIV0) ? rem_r[s-1][i] : {rem_r[s-1][i][SUM_W-1:0], 1'b0};
          if (rm >= {1'b0, den_r[s-1]}) begin
            rem_r[s][i] <= rm - {1'b0, den_r[s-1]};
            quo_r[s][i] <= {quo_r[s-1][i][QUO_W-2:0], 1'b1};
          end else begin
            rem_r[s][i] <= rm;
            quo_r[s][i] <= {quo_r[s-1][i][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // square root: one root bit per stage, bit-pair from the quotient
  logic [QUO_W:0] qext [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      qext[i] = (den_r[S_SQ0-1] == '0) ? '0 : {1'b0, quo_r[S_SQ0-1][i]};
  end

  logic [QUO_W:0] qhold_r [NSTAGE][3];
  for (genvar s = S_SQ0; s < S_MUL; s++) begin : g_sqrt
    localparam int B = S_MUL - 1 - s;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          logic [QUO_W:0] q, rm, trial;
          logic [FAC_W-1:0] rt;
          q  = (s == S_SQ0) ? qext[i] : qhold_r[s-1][i];
          rm = (s == S_SQ0) ? '0 : srem_r[s-1][i];
          rt = (s == S_SQ0) ? '0 : root_r[s-1][i];
          rm = {rm[QUO_W-2:0], q[2*B+1 -: 2]};
          trial = (QUO_W+1)'({rt, 2'b01});
          if (rm >= trial) begin
            srem_r[s][i] <= rm - trial;
            root_r[s][i] <= {rt[FAC_W-2:0], 1'b1};
          end else begin
            srem_r[s][i] <= rm;
            root_r[s][i] <= {rt[FAC_W-2:0], 1'b0};
          end
          qhold_r[s][i] <= q;
        end
      end
    end
  end

  // products, full 48-bit before dropping the 16 fraction bits
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [PROD_W-1:0] p0, p1;
        p0 = PROD_W'(r0_r[S_MUL-1]) * PROD_W'(root_r[S_MUL-1][i]);
        p1 = PROD_W'(r1_r[S_MUL-1]) * PROD_W'(root_r[S_MUL-1][i]);
        x0_r[i] <= EXT_W'(p0 >> 16);
        x1_r[i] <= EXT_W'(p1 >> 16);
      end
    end
  end

  // edges
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= EDGE_W'(bp_r[S_MUL][i]) - EDGE_W'(signed'({1'b0, x0_r[i]}));
        c_r[i] <= EDGE_W'(bp_r[S_MUL][i]) + EDGE_W'(signed'({1'b0, x0_r[i]}));
        b_r[i] <= EDGE_W'(ep_r[S_MUL][i]) - EDGE_W'(signed'({1'b0, x1_r[i]}));
        e_r[i] <= EDGE_W'(ep_r[S_MUL][i]) + EDGE_W'(signed'({1'b0, x1_r[i]}));
      end
    end
  end

  function automatic coord_t sat(input logic signed [EDGE_W-1:0] v);
    if (v < -EDGE_W'(64'sh80000000))     sat = 32'sh80000000;
    else if (v > EDGE_W'(64'sh7FFFFFFF)) sat = 32'sh7FFFFFFF;
    else                                 sat = COORD_W'(v);
  endfunction

  // min/max and saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= (i < AXES) ? sat((a_r[i] < b_r[i]) ? a_r[i] : b_r[i]) : '0;
        hi_r[i] <= (i < AXES) ? sat((c_r[i] > e_r[i]) ? c_r[i] : e_r[i]) : '0;
      end
    end
  end

  // payload carry line
  for (genvar s = 1; s < NSTAGE; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv) begin
        bp_r[s] <= bp_r[s-1];
        ep_r[s] <= ep_r[s-1];
        r0_r[s] <= r0_r[s-1];
        r1_r[s] <= r1_r[s-1];
      end
    end
  end

  assign out_tdata = {hi_r[2], hi_r[1], hi_r[0], lo_r[2], lo_r[1], lo_r[0]};

endmodule

### tb/cfbb_checker.sv
// checker for the cone frustum bounding box unit: watches both channels,
// predicts each box and compares it field by field. depends on cfbb_pkg
`timescale 1ns / 100ps
module cfbb_checker #(
  parameter int AXES = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [cfbb_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [cfbb_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int   error_count,
  output int   pending_boxes
);
  import cfbb_pkg::*;

  typedef struct packed {
    coord_t hi_z, hi_y, hi_x, lo_z, lo_y, lo_x;
  } box_t;

  box_t expected_boxes[$];

  function automatic longint unsigned isqrt64(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // floor(num * 2^32 / den), num <= den
  function automatic longint unsigned ratio_q32(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q, rem;
    q = 0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem -= den;
    end
    for (int n = 0; n < 32; n++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic box_t frustum_box(input logic [IN_TDATA_W-1:0] d);
    longint p0[3], p1[3], lo[3], hi[3];
    longint unsigned mag[3], fac[3], biggest, total, r0, r1, x0, x1;
    int shift;
    box_t b;
    r0 = d[6*COORD_W +: RADIUS_W];
    r1 = d[6*COORD_W+RADIUS_W +: RADIUS_W];
    biggest = 0;
    total = 0;
    shift = 0;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'(coord_t'(d[i*COORD_W +: COORD_W]));
      p1[i] = longint'(coord_t'(d[(3+i)*COORD_W +: COORD_W]));
      mag[i] = (p1[i] > p0[i]) ? p1[i] - p0[i] : p0[i] - p1[i];
      fac[i] = 0;
      lo[i] = 0;
      hi[i] = 0;
    end
    for (int i = 0; i < AXES; i++) if (mag[i] > biggest) biggest = mag[i];
    while ((biggest >> shift) >= 64'h4000_0000) shift++;
    for (int i = 0; i < AXES; i++) begin
      mag[i] >>= shift;
      total += mag[i] * mag[i];
    end
    // zero length axis leaves every extent at zero
    if (total != 0)
      for (int i = 0; i < AXES; i++)
        fac[i] = isqrt64(ratio_q32(total - mag[i] * mag[i], total));
    for (int i = 0; i < AXES; i++) begin
      x0 = (r0 * fac[i]) >> 16;
      x1 = (r1 * fac[i]) >> 16;
      lo[i] = clamp32((p0[i] - longint'(x0) < p1[i] - longint'(x1)) ?
                      p0[i] - longint'(x0) : p1[i] - longint'(x1));
      hi[i] = clamp32((p0[i] + longint'(x0) > p1[i] + longint'(x1)) ?
                      p0[i] + longint'(x0) : p1[i] + longint'(x1));
    end
    b.lo_x = lo[0][31:0]; b.lo_y = lo[1][31:0]; b.lo_z = lo[2][31:0];
    b.hi_x = hi[0][31:0]; b.hi_y = hi[1][31:0]; b.hi_z = hi[2][31:0];
    return b;
  endfunction

  task automatic compare_field(input string name, input coord_t exp_v, input coord_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  initial begin
    error_count = 0;
    pending_boxes = 0;
  end

  always @(posedge clk) begin
    box_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_boxes.push_back(frustum_box(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_boxes.size() == 0) begin
          $error("unexpected output transaction %h", out_tdata);
          error_count++;
        end else begin
          want = expected_boxes.pop_front();
          compare_field("low_x", want.lo_x, got.lo_x);
          compare_field("low_y", want.lo_y, got.lo_y);
          compare_field("low_z", want.lo_z, got.lo_z);
          compare_field("high_x", want.hi_x, got.hi_x);
          compare_field("high_y", want.hi_y, got.hi_y);
          compare_field("high_z", want.hi_z, got.hi_z);
        end
      end
    end
    pending_boxes = expected_boxes.size();
  end
endmodule

### tb/tb_cone_frustum_bounding_box_unit.sv
// testbench top for the cone frustum bounding box unit: drives frustum
// transactions with random gaps and stalls; cfbb_checker does the checking
`timescale 1ns / 100ps
module tb_cone_frustum_bounding_box_unit;
  import cfbb_pkg::*;

  localparam int AXES = 3;
  localparam int RANDOM_ITEMS = 1030;
  localparam int IDLE_LIMIT = 5000;   // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 300;  // beyond the pipeline depth

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int error_count, pending_boxes;
  int idle_cycles;
  bit quiet_phase;  // no gaps and no stalls while set

  cone_frustum_bounding_box_unit #(.AXES(AXES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  cfbb_checker #(.AXES(AXES)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .error_count(error_count), .pending_boxes(pending_boxes)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // random gap length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one frustum transaction; valid stays high when no gap follows
  task automatic send_frustum(input coord_t bx, by, bz, ex, ey, ez,
                              input radius_t r0, r1);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, r1, r0, ez, ey, ex, bz, by, bx};
    do @(posedge clk); while (!in_tready);
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // coordinate mix: full range, near zero, near the limits
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2 * 65536) - 65536;
      1: return 32'sh7fff_ffff - $urandom_range(0, 1 << 20);
      2: return 32'sh8000_0000 + $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic radius_t pick_radius();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 1 << 20);
      1: return 31'h7fff_ffff - $urandom_range(0, 1 << 16);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls with occasional long ones
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || quiet_phase) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : 0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    coord_t a;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    quiet_phase = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero length axis, extremes, single-axis and diagonal axes
    send_frustum(0, 0, 0, 0, 0, 0, 0, 0);
    send_frustum(32'sh10000, -32'sh20000, 5, 32'sh10000, -32'sh20000, 5,
                 31'h7fff_ffff, 31'h7fff_ffff);
    send_frustum(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 31'h7fff_ffff, 31'h7fff_ffff);
    send_frustum(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 31'h7fff_ffff, 0);
    send_frustum(32'sh7fff_ffff, 32'sh8000_0000, 0,
                 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 31'h7fff_ffff);
    send_frustum(0, 0, 0, 32'sh50000, 0, 0, 32'sh10000, 32'sh20000);
    send_frustum(0, 0, 0, 0, -32'sh50000, 0, 32'sh30000, 32'sh8000);
    send_frustum(0, 0, 0, 0, 0, 1, 31'h7fff_ffff, 31'h7fff_ffff);
    send_frustum(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
    send_frustum(32'sh7fff_0000, 32'sh7fff_0000, 32'sh7fff_0000, 32'sh7fff_0000,
                 32'sh7fff_0000, 32'sh7fff_8000, 31'h7fff_ffff, 31'h7fff_ffff);
    send_frustum(32'sh8000_0000, 0, 0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 1, 1);
    send_frustum(3, -7, 11, -3, 7, -11, 31'h5555_5555, 31'h2aaa_aaaa);
    send_frustum(-1, -1, -1, 1, 1, 1, 31'h7fff_ffff, 31'h7fff_ffff);
    send_frustum(0, 0, 0, 1, 0, 0, 31'h7fff_ffff, 31'h7fff_ffff);
    send_frustum(32'sh4000_0000, -32'sh4000_0000, 0,
                 -32'sh4000_0000, 32'sh4000_0000, 32'sh1000, 32'sh10000, 0);
    for (int i = 0; i < 5; i++)
      send_frustum($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);

    // random part, with stretches that never idle
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) quiet_phase <= ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0: begin
          // zero length axis with random point
          a = pick_coord();
          send_frustum(a, a ^ 32'h0f0f, ~a, a, a ^ 32'h0f0f, ~a,
                       pick_radius(), pick_radius());
        end
        1: begin
          // short axis around a random point
          a = pick_coord();
          send_frustum(a, a, a, a + $urandom_range(0, 3), a - $urandom_range(0, 3),
                       a, pick_radius(), pick_radius());
        end
        default:
          send_frustum(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       pick_coord(), pick_coord(), pick_radius(), pick_radius());
      endcase
    end
    in_tvalid <= 1'b0;
    quiet_phase <= 1'b0;

    while (pending_boxes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_boxes == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
